// ----- rtl/core/ghtbl_pkg.sv -----
// Package for the generation-tagged handle table.
// Holds the request and response transaction types, codes and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package ghtbl_pkg;

    // Fixed field widths
    localparam int SLOT_W = 10;
    localparam int ID_W   = 32;
    localparam int GEN_W  = 21;

    // Request codes
    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_MKCUR  = 2'd3
    } t_mode;

    // Response codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_BAD     = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Request transaction
    typedef struct packed {
        t_mode               mode;
        logic [ID_W-1:0]     lookup_id;
        logic [ID_W-1:0]     parent_handle;
        logic                check_perm;
        logic [SLOT_W-1:0]   slot_index;
    } t_req;

    // Response transaction
    typedef struct packed {
        t_status             status;
        logic                found_valid;
        logic [SLOT_W-1:0]   found_slot;
        logic [ID_W-1:0]     found_id;
    } t_rsp;

    // One slot table word
    typedef struct packed {
        logic                in_use;
        logic [ID_W-1:0]     parent;
        logic [ID_W-1:0]     id;
    } t_slot_ent;

endpackage

// ----- rtl/core/generation_tagged_handle_table.sv -----
// Generation-tagged handle table: slot table, free stack and request sequencer.
// Depends on ghtbl_pkg.
//
// Usage:
//   Requests enter on i_in_valid / o_in_stall with an ghtbl_pkg::t_req payload
//   (allocate, free, lookup by id, make current). Every request returns exactly
//   one response on o_out_valid / i_out_stall with an ghtbl_pkg::t_rsp payload.
//   A transaction is taken at a clock edge where valid is high and stall is low.
// Sequencing:
//   One request at a time. The edge that accepts a request also issues the
//   reads of the slot table (target and current slot) and of the free stack top;
//   the evaluate state then evaluates, writes back and loads the response
//   register in a single read-modify-write pass through the slot table, once
//   the response register is free.
// Stall:
//   The response register holds while i_out_stall is high; a new request may be
//   accepted meanwhile, and it waits in its evaluate cycle until the register
//   frees up.
// Reset:
//   Synchronous, active low. All slots are free right after reset with no
//   clearing pass: a high-water mark of stack depth tells which stack entries
//   and which in-use bits were ever written, and older entries read as reset.
`timescale 1ns / 1ps

module generation_tagged_handle_table #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ghtbl_pkg::t_req   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ghtbl_pkg::t_rsp   o_out_data
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int TW = IW + 1;
    localparam int SW = ghtbl_pkg::SLOT_W;
    localparam int GW = ghtbl_pkg::GEN_W;
    localparam int DW = ghtbl_pkg::ID_W;

    // Memories
    ghtbl_pkg::t_slot_ent r_slot_mem [NUM_SLOTS];
    logic [IW-1:0]        r_stack_mem [NUM_SLOTS];

    // Registers
    ghtbl_pkg::t_state    r_state, n_state;
    ghtbl_pkg::t_req      r_req;
    ghtbl_pkg::t_slot_ent r_rd_a, r_rd_b;
    logic [IW-1:0]        r_stk_rd;
    logic [TW-1:0]        r_top, n_top;
    logic [TW-1:0]        r_hwm, n_hwm;
    logic [GW-1:0]        r_gen, n_gen;
    logic [IW-1:0]        r_cur_slot, n_cur_slot;
    logic                 r_cur_valid, n_cur_valid;
    logic                 r_out_valid, n_out_valid;
    ghtbl_pkg::t_rsp      r_out_data, n_out_data;

    // Combinational
    logic                 w_in_acc;
    logic                 w_done;
    logic [IW-1:0]        w_rd_addr;
    logic [IW-1:0]        w_tgt;
    logic [IW-1:0]        w_si;
    logic [IW-1:0]        w_a_addr;
    logic                 w_si_ok;
    logic                 w_tgt_ok;
    logic                 w_a_used;
    logic                 w_full;
    logic [IW-1:0]        w_pop_slot;
    logic [GW-1:0]        w_gen_inc;
    logic [DW-1:0]        w_new_id;
    logic                 w_perm_ok;
    ghtbl_pkg::t_rsp      w_rsp;
    logic                 w_alloc_ok;
    logic                 w_free_ok;
    logic                 w_mkcur_ok;
    logic                 w_slot_we;
    logic [IW-1:0]        w_slot_waddr;
    ghtbl_pkg::t_slot_ent w_slot_wdata;
    logic                 w_stk_we;
    logic [IW-1:0]        w_stk_waddr;

    // Sequencer: one request at a time, evaluate waits for the response register
    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != ghtbl_pkg::S_IDLE);
        w_in_acc   = 1'b0;
        w_done     = 1'b0;
        case (r_state)
            ghtbl_pkg::S_IDLE: begin
                w_in_acc = i_in_valid;
                if (i_in_valid) begin
                    n_state = ghtbl_pkg::S_EXEC;
                end
            end
            ghtbl_pkg::S_EXEC: begin
                w_done = !r_out_valid || !i_out_stall;
                if (w_done) begin
                    n_state = ghtbl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ghtbl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ghtbl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read address of the target slot at acceptance
    always_comb begin
        if (i_in_data.mode == ghtbl_pkg::MODE_LOOKUP) begin
            w_rd_addr = i_in_data.lookup_id[IW-1:0];
        end else begin
            w_rd_addr = IW'(i_in_data.slot_index);
        end
    end

    // Slot table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_waddr] <= w_slot_wdata;
        end
        if (w_in_acc) begin
            r_rd_a <= r_slot_mem[w_rd_addr];
            r_rd_b <= r_slot_mem[r_cur_slot];
        end
    end

    // Free stack: one write port, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack_mem[w_stk_waddr] <= w_si;
        end
        if (w_in_acc) begin
            r_stk_rd <= r_stack_mem[r_top[IW-1:0]];
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_in_data;
        end
    end

    // Evaluate: decode read data against the request
    always_comb begin
        w_tgt     = r_req.lookup_id[IW-1:0];
        w_si      = IW'(r_req.slot_index);
        w_si_ok   = 32'(r_req.slot_index) < 32'(NUM_SLOTS);
        w_tgt_ok  = 32'(w_tgt) < 32'(NUM_SLOTS);
        w_a_addr  = (r_req.mode == ghtbl_pkg::MODE_LOOKUP) ? w_tgt : w_si;
        // slots at or above the high-water mark were never allocated
        w_a_used  = (TW'(w_a_addr) < r_hwm) && r_rd_a.in_use;
        w_full    = (r_top == TW'(NUM_SLOTS));
        // stack entries at or above the high-water mark still hold their index
        w_pop_slot = (r_top == r_hwm) ? r_top[IW-1:0] : r_stk_rd;
        w_gen_inc = r_gen + GW'(1);
        w_new_id  = DW'({w_gen_inc, 1'b0, w_pop_slot});
        w_perm_ok = r_cur_valid && ((w_tgt == r_cur_slot) || (r_rd_b.id == r_rd_a.parent));

        w_rsp       = '0;
        w_rsp.status = ghtbl_pkg::STAT_OK;
        w_alloc_ok  = 1'b0;
        w_free_ok   = 1'b0;
        w_mkcur_ok  = 1'b0;
        case (r_req.mode)
            ghtbl_pkg::MODE_ALLOC: begin
                if (w_full) begin
                    w_rsp.status = ghtbl_pkg::STAT_NO_FREE;
                end else begin
                    w_alloc_ok        = 1'b1;
                    w_rsp.found_valid = 1'b1;
                    w_rsp.found_slot  = SW'(w_pop_slot);
                    w_rsp.found_id    = w_new_id;
                end
            end
            ghtbl_pkg::MODE_FREE: begin
                if (!w_si_ok || !w_a_used || (r_top == '0)) begin
                    w_rsp.status = ghtbl_pkg::STAT_BAD;
                end else begin
                    w_free_ok = 1'b1;
                end
            end
            ghtbl_pkg::MODE_MKCUR: begin
                if (!w_si_ok) begin
                    w_rsp.status = ghtbl_pkg::STAT_BAD;
                end else begin
                    w_mkcur_ok = 1'b1;
                end
            end
            ghtbl_pkg::MODE_LOOKUP: begin
                if (r_req.lookup_id == '0) begin
                    // id zero names the current slot, no checks
                    if (r_cur_valid) begin
                        w_rsp.found_valid = 1'b1;
                        w_rsp.found_slot  = SW'(r_cur_slot);
                        w_rsp.found_id    = r_rd_b.id;
                    end
                end else if (!w_tgt_ok || !w_a_used || (r_rd_a.id != r_req.lookup_id) ||
                             (r_req.check_perm && !w_perm_ok)) begin
                    w_rsp.status = ghtbl_pkg::STAT_BAD;
                end else begin
                    w_rsp.found_valid = 1'b1;
                    w_rsp.found_slot  = SW'(w_tgt);
                    w_rsp.found_id    = r_rd_a.id;
                end
            end
            default: begin
                w_rsp.status = ghtbl_pkg::STAT_BAD;
            end
        endcase
    end

    // Write-back and next values, committed when the response register frees up
    always_comb begin
        n_top        = r_top;
        n_hwm        = r_hwm;
        n_gen        = r_gen;
        n_cur_slot   = r_cur_slot;
        n_cur_valid  = r_cur_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        w_slot_we    = 1'b0;
        w_slot_waddr = w_si;
        w_slot_wdata = '{in_use: 1'b0, parent: r_rd_a.parent, id: r_rd_a.id};
        w_stk_we     = 1'b0;
        w_stk_waddr  = r_top[IW-1:0] - IW'(1);
        if (w_done) begin
            n_out_valid = 1'b1;
            n_out_data  = w_rsp;
            if (w_alloc_ok) begin
                // pop: top moves up, high-water mark follows it
                n_top        = r_top + TW'(1);
                n_hwm        = (r_top == r_hwm) ? (r_top + TW'(1)) : r_hwm;
                n_gen        = w_gen_inc;
                w_slot_we    = 1'b1;
                w_slot_waddr = w_pop_slot;
                w_slot_wdata = '{in_use: 1'b1, parent: r_req.parent_handle, id: w_new_id};
            end
            if (w_free_ok) begin
                // push: slot goes back just below the top
                n_top     = r_top - TW'(1);
                w_slot_we = 1'b1;
                w_stk_we  = 1'b1;
                if (r_cur_valid && (r_cur_slot == w_si)) begin
                    n_cur_valid = 1'b0;
                end
            end
            if (w_mkcur_ok) begin
                n_cur_slot  = w_si;
                n_cur_valid = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_hwm       <= '0;
            r_gen       <= '0;
            r_cur_slot  <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_hwm       <= n_hwm;
            r_gen       <= n_gen;
            r_cur_slot  <= n_cur_slot;
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/ghtbl_chk.sv -----
// Port-level checker for the generation-tagged handle table, with its bind.
// Depends on ghtbl_pkg and the generation_tagged_handle_table ports.
`timescale 1ns / 1ps

module ghtbl_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input ghtbl_pkg::t_rsp   o_out_data
);

    // One request in flight: the cycle after a transaction the input is stalled
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // A response that names no slot carries zero slot and id
    a_empty_rsp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found_valid) |->
        (o_out_data.found_slot == '0 && o_out_data.found_id == '0))
        else $error("response without slot carries nonzero fields");

    // Failed requests never name a slot
    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ghtbl_pkg::STAT_OK) |->
        !o_out_data.found_valid)
        else $error("failed request names a slot");

    // A new response only follows an accepted request
    a_rsp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("response without a pending request");

    // Stalled response holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled response changed");

endmodule

bind generation_tagged_handle_table ghtbl_chk u_ghtbl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- bench/tb_generation_tagged_handle_table.sv -----
// Self-checking testbench for the generation-tagged handle table.
// Drives allocate, free, lookup and make-current transactions, predicts each response
// from a local copy of the slot table and compares it field by field. Depends on ghtbl_pkg.
`timescale 1ns / 1ps

module tb_generation_tagged_handle_table;

    localparam int NUM_SLOTS   = 1024;
    localparam int IDX_W       = $clog2(NUM_SLOTS);
    localparam int SLOT_W      = ghtbl_pkg::SLOT_W;
    localparam int ID_W        = ghtbl_pkg::ID_W;
    localparam int GEN_W       = ghtbl_pkg::GEN_W;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int MAX_PRINTS  = 50;

    // Clock, reset and DUT connections
    logic             i_clk;
    logic             rst_n     = 1'b0;
    logic             drv_valid = 1'b0;
    ghtbl_pkg::t_req  drv_req   = '0;
    logic             rcv_stall = 1'b0;
    logic             dut_in_stall;
    logic             dut_out_valid;
    ghtbl_pkg::t_rsp  dut_out_rsp;

    // Pending requests with their predicted responses, and responses now owed
    ghtbl_pkg::t_req  req_q[$];
    ghtbl_pkg::t_rsp  rsp_q[$];
    ghtbl_pkg::t_rsp  owed_rsp_q[$];
    ghtbl_pkg::t_rsp  staged_rsp;

    // Traffic shaping, set by the sequence
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    hold_seq       = 0;
    int    hold_taken     = 0;
    int    hold_left      = 0;
    int    err_count      = 0;
    int    idle_cycles    = 0;

    // Local copy of the slot table
    logic [SLOT_W-1:0] tbl_stack   [NUM_SLOTS];
    logic              tbl_in_use  [NUM_SLOTS];
    logic              tbl_written [NUM_SLOTS];
    logic [ID_W-1:0]   tbl_id      [NUM_SLOTS];
    logic [ID_W-1:0]   tbl_parent  [NUM_SLOTS];
    int                tbl_free_count;
    int                tbl_high;
    logic [GEN_W-1:0]  tbl_gen;
    logic [SLOT_W-1:0] tbl_cur_slot;
    logic              tbl_cur_valid;

    generation_tagged_handle_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (drv_valid),
        .o_in_stall  (dut_in_stall),
        .i_in_data   (drv_req),
        .o_out_valid (dut_out_valid),
        .i_out_stall (rcv_stall),
        .o_out_data  (dut_out_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Applies one request to the local table and returns the response it owes
    function automatic ghtbl_pkg::t_rsp resolve_request(ghtbl_pkg::t_req r);
        ghtbl_pkg::t_rsp   rsp;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] t;
        logic              ok;
        rsp = '0;
        rsp.status = ghtbl_pkg::STAT_OK;
        case (r.mode)
            ghtbl_pkg::MODE_ALLOC: begin
                if (tbl_free_count == 0) begin
                    rsp.status = ghtbl_pkg::STAT_NO_FREE;
                end else begin
                    s = tbl_stack[IDX_W'(NUM_SLOTS - tbl_free_count)];
                    tbl_free_count--;
                    tbl_gen = tbl_gen + 1'b1;
                    // generation sits above the index bits and one spare bit
                    tbl_id[s]      = (ID_W'(tbl_gen) << (IDX_W + 1)) | ID_W'(s);
                    tbl_parent[s]  = r.parent_handle;
                    tbl_in_use[s]  = 1'b1;
                    tbl_written[s] = 1'b1;
                    if (int'(s) > tbl_high) tbl_high = int'(s);
                    rsp.found_valid = 1'b1;
                    rsp.found_slot  = s;
                    rsp.found_id    = tbl_id[s];
                end
            end
            ghtbl_pkg::MODE_FREE: begin
                if (int'(r.slot_index) >= NUM_SLOTS || !tbl_in_use[r.slot_index] ||
                    tbl_free_count >= NUM_SLOTS) begin
                    rsp.status = ghtbl_pkg::STAT_BAD;
                end else begin
                    tbl_in_use[r.slot_index] = 1'b0;
                    tbl_free_count++;
                    tbl_stack[IDX_W'(NUM_SLOTS - tbl_free_count)] = r.slot_index;
                    if (tbl_cur_valid && tbl_cur_slot == r.slot_index) tbl_cur_valid = 1'b0;
                end
            end
            ghtbl_pkg::MODE_MKCUR: begin
                if (int'(r.slot_index) >= NUM_SLOTS) begin
                    rsp.status = ghtbl_pkg::STAT_BAD;
                end else begin
                    tbl_cur_slot  = r.slot_index;
                    tbl_cur_valid = 1'b1;
                end
            end
            default: begin
                if (r.lookup_id == '0) begin
                    // id zero names the current slot, no checks
                    if (tbl_cur_valid) begin
                        rsp.found_valid = 1'b1;
                        rsp.found_slot  = tbl_cur_slot;
                        rsp.found_id    = tbl_id[tbl_cur_slot];
                    end
                end else begin
                    t = r.lookup_id[IDX_W-1:0];
                    ok = tbl_in_use[t] && tbl_id[t] == r.lookup_id;
                    if (ok && r.check_perm)
                        ok = tbl_cur_valid && (t == tbl_cur_slot ||
                                               tbl_id[tbl_cur_slot] == tbl_parent[t]);
                    if (!ok) begin
                        rsp.status = ghtbl_pkg::STAT_BAD;
                    end else begin
                        rsp.found_valid = 1'b1;
                        rsp.found_slot  = t;
                        rsp.found_id    = tbl_id[t];
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic ghtbl_pkg::t_req build_req(ghtbl_pkg::t_mode m, logic [ID_W-1:0] lid,
                                                  logic [ID_W-1:0] pid, logic chk,
                                                  logic [SLOT_W-1:0] si);
        ghtbl_pkg::t_req r;
        r.mode          = m;
        r.lookup_id     = lid;
        r.parent_handle = pid;
        r.check_perm    = chk;
        r.slot_index    = si;
        return r;
    endfunction

    // Queue a request with its predicted response. A current slot that was
    // never allocated has no id yet, so lookups must not read it.
    task automatic add_item(ghtbl_pkg::t_req r);
        if (r.mode == ghtbl_pkg::MODE_LOOKUP && tbl_cur_valid &&
            !tbl_written[tbl_cur_slot]) begin
            if (r.lookup_id == '0) r.lookup_id = $urandom | 32'h0000_0800;
            r.check_perm = 1'b0;
        end
        rsp_q.push_back(resolve_request(r));
        req_q.push_back(r);
    endtask

    // Random slot currently in use, or -1 when none is found
    function automatic int pick_live();
        int k;
        int s;
        for (k = 0; k < 16; k++) begin
            s = $urandom_range(0, tbl_high);
            if (tbl_in_use[IDX_W'(s)]) return s;
        end
        return -1;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (req_q.size() != 0 || drv_valid || owed_rsp_q.size() != 0) @(negedge i_clk);
    endtask

    // Directed corner cases on a fresh table
    task automatic run_directed();
        logic [ID_W-1:0] id0;
        logic [ID_W-1:0] id1;
        logic [ID_W-1:0] id2;
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, '0, '0, 1'b0, '0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, '1, '1, 1'b1, '1));
        add_item(build_req(ghtbl_pkg::MODE_ALLOC, '0, '0, 1'b0, '0));
        id0 = tbl_id[0];
        add_item(build_req(ghtbl_pkg::MODE_ALLOC, '0, id0, 1'b0, '0));
        id1 = tbl_id[1];
        add_item(build_req(ghtbl_pkg::MODE_ALLOC, '0, '1, 1'b1, '1));
        id2 = tbl_id[2];
        // permission check with no current slot fails
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, id1, '0, 1'b1, '0));
        add_item(build_req(ghtbl_pkg::MODE_MKCUR, '0, '0, 1'b0, 10'd0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, id1, '0, 1'b1, '0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, id0, '0, 1'b1, '0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, id2, '0, 1'b1, '0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, id2, '0, 1'b0, '0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, '0, '0, 1'b1, '0));
        // stale generation
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, id1 ^ 32'h0000_0800, '0, 1'b0, '0));
        // freeing the current slot drops current; a second free is refused
        add_item(build_req(ghtbl_pkg::MODE_FREE, '0, '0, 1'b0, 10'd0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, '0, '0, 1'b0, '0));
        add_item(build_req(ghtbl_pkg::MODE_FREE, '0, '0, 1'b0, 10'd0));
        // a free slot may be made current
        add_item(build_req(ghtbl_pkg::MODE_MKCUR, '0, '0, 1'b0, 10'd0));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, '0, '0, 1'b0, '0));
        add_item(build_req(ghtbl_pkg::MODE_ALLOC, '0, '1, 1'b0, '0));
        add_item(build_req(ghtbl_pkg::MODE_MKCUR, '0, '0, 1'b0, 10'd1023));
        add_item(build_req(ghtbl_pkg::MODE_MKCUR, '0, '0, 1'b0, 10'd1));
        add_item(build_req(ghtbl_pkg::MODE_FREE, '0, '0, 1'b0, 10'd1023));
        add_item(build_req(ghtbl_pkg::MODE_LOOKUP, 32'h0000_03FF, '0, 1'b0, '0));
    endtask

    // Mostly well-formed traffic on live handles, with some noise
    task automatic run_random(int n);
        int              k;
        int              roll;
        int              sub;
        int              live;
        logic [ID_W-1:0] pid;
        logic [ID_W-1:0] lid;
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            sub  = $urandom_range(0, 9);
            live = pick_live();
            if (roll < 30) begin
                if (sub < 5 && tbl_cur_valid && tbl_written[tbl_cur_slot])
                    pid = tbl_id[tbl_cur_slot];
                else if (sub < 8 && live >= 0)
                    pid = tbl_id[IDX_W'(live)];
                else
                    pid = $urandom;
                add_item(build_req(ghtbl_pkg::MODE_ALLOC, $urandom, pid,
                                   1'($urandom_range(0, 1)), SLOT_W'($urandom)));
            end else if (roll < 45) begin
                add_item(build_req(ghtbl_pkg::MODE_FREE, $urandom, $urandom,
                                   1'($urandom_range(0, 1)),
                                   (live >= 0 && sub < 8) ? SLOT_W'(live) : SLOT_W'($urandom)));
            end else if (roll < 85) begin
                if (live >= 0 && sub < 7)
                    lid = tbl_id[IDX_W'(live)];
                else if (sub == 7)
                    lid = '0;
                else if (live >= 0 && sub == 8)
                    lid = tbl_id[IDX_W'(live)] ^ (32'd1 << $urandom_range(0, 31));
                else
                    lid = $urandom;
                add_item(build_req(ghtbl_pkg::MODE_LOOKUP, lid, $urandom,
                                   1'($urandom_range(0, 1)), SLOT_W'($urandom)));
            end else begin
                add_item(build_req(ghtbl_pkg::MODE_MKCUR, $urandom, $urandom,
                                   1'($urandom_range(0, 1)),
                                   (live >= 0 && sub < 8) ? SLOT_W'(live) : SLOT_W'($urandom)));
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
        if (err_count < MAX_PRINTS)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        err_count++;
    endtask

    // Request driver: valid holds until the transaction is taken
    always @(posedge i_clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || !dut_in_stall) begin
            if (drv_valid) owed_rsp_q.push_back(staged_rsp);
            if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_req    <= req_q.pop_front();
                staged_rsp  = rsp_q.pop_front();
                drv_valid  <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Response stall: random, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rcv_stall <= 1'b0;
        end else if (hold_seq != hold_taken) begin
            hold_taken <= hold_seq;
            hold_left  <= HOLD_CYCLES;
            rcv_stall  <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rcv_stall <= 1'b1;
        end else begin
            rcv_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        ghtbl_pkg::t_rsp want;
        if (rst_n && dut_out_valid && !rcv_stall) begin
            if (owed_rsp_q.size() == 0) begin
                report_mismatch("unexpected response id", '0, dut_out_rsp.found_id);
            end else begin
                want = owed_rsp_q.pop_front();
                if (dut_out_rsp.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(dut_out_rsp.status));
                if (dut_out_rsp.found_valid !== want.found_valid)
                    report_mismatch("found_valid", 32'(want.found_valid),
                                    32'(dut_out_rsp.found_valid));
                if (dut_out_rsp.found_slot !== want.found_slot)
                    report_mismatch("found_slot", 32'(want.found_slot),
                                    32'(dut_out_rsp.found_slot));
                if (dut_out_rsp.found_id !== want.found_id)
                    report_mismatch("found_id", want.found_id, dut_out_rsp.found_id);
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((drv_valid && !dut_in_stall) || (dut_out_valid && !rcv_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            tbl_stack[IDX_W'(k)]   = SLOT_W'(k);
            tbl_in_use[IDX_W'(k)]  = 1'b0;
            tbl_written[IDX_W'(k)] = 1'b0;
            tbl_id[IDX_W'(k)]      = '0;
            tbl_parent[IDX_W'(k)]  = '0;
        end
        tbl_free_count = NUM_SLOTS;
        tbl_high       = 0;
        tbl_gen        = '0;
        tbl_cur_slot   = '0;
        tbl_cur_valid  = 1'b0;

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        @(negedge i_clk);
        run_directed();
        wait_drained();

        run_random(150);
        wait_drained();

        // receiver holds off while requests keep coming
        hold_seq = hold_seq + 1;
        run_random(40);
        wait_drained();

        send_idle_pct = 57;
        run_random(150);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 57;
        run_random(150);
        wait_drained();

        send_idle_pct  = 33;
        recv_stall_pct = 33;
        run_random(150);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
